@@ hdl/bcdalu_pkg.sv @@
// package: operation codes, flag positions and the result bundle of the bcd-capable alu
package bcdalu_pkg;

	localparam int DATA_W = 8;
	localparam int OP_W   = 4;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [OP_W-1:0]   op_code_t;

	typedef enum logic [OP_W-1:0] {
		OP_ADC  = 4'd0,
		OP_SBC  = 4'd1,
		OP_CMP  = 4'd2,
		OP_AND  = 4'd3,
		OP_ORA  = 4'd4,
		OP_EOR  = 4'd5,
		OP_BIT  = 4'd6,
		OP_ASL  = 4'd7,
		OP_LSR  = 4'd8,
		OP_ROL  = 4'd9,
		OP_ROR  = 4'd10,
		OP_INC  = 4'd11,
		OP_DEC  = 4'd12,
		OP_LOAD = 4'd13
	} alu_op_t;

	// status bit positions
	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_D = 3;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	// decimal adjust constants
	localparam logic [4:0] BCD_DIGIT_MAX = 5'h09;
	localparam logic [9:0] BCD_LO_FIX    = 10'h006;
	localparam logic [9:0] BCD_HI_MAX    = 10'h09F;
	localparam logic [9:0] BCD_HI_FIX    = 10'h060;
	localparam logic [9:0] BCD_HI_STEP   = 10'h010;

	typedef struct packed {
		data_t result;
		data_t status;
		logic  writes_result;
	} alu_res_t;

endpackage

@@ hdl/bcd_capable_8bit_alu_unit.sv @@
// top level: input register, alu datapath and result register
//
// usage
//  - an operation transfers in at a rising edge with start high and busy low;
//    busy is held low, so a new operation may transfer in every cycle
//  - the operation is registered into stage 1, evaluated by one pass of
//    combinational logic (binary or nmos-style decimal adc/sbc, compare,
//    logic ops, bit test, shifts, inc/dec, load) and registered into stage 2
//  - the result appears on result, status_out and writes_result once the
//    stage 1 and stage 2 registers have passed it, marked by done for exactly one
//    cycle; throughput is one operation per cycle, set by the single-pass
//    datapath between the two register stages
//  - writes_result is low for compare, bit test and unused op codes
//  - the receiver cannot stall: each result transfers out at the edge that
//    ends its done cycle
//  - reset (arst_n low) clears both stage valid bits, so no result is
//    reported from anything in flight; payload registers are not reset
//  - there is no configuration and no state between operations
module bcd_capable_8bit_alu_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bcdalu_pkg::op_code_t op,
	input  bcdalu_pkg::data_t    reg_value,
	input  bcdalu_pkg::data_t    operand,
	input  bcdalu_pkg::data_t    status_in,
	output logic                 done,
	output bcdalu_pkg::data_t    result,
	output bcdalu_pkg::data_t    status_out,
	output logic                 writes_result
);
	import bcdalu_pkg::*;

	logic     take;
	// stage 1: registered input
	logic     valid_s1;
	op_code_t op_s1;
	data_t    a_s1;
	data_t    m_s1;
	data_t    st_s1;
	// stage 2: registered result
	logic     valid_s2;
	alu_res_t res_s2;
	alu_res_t res_comb;

	// never blocks: a transfer is possible every cycle
	assign busy = 1'b0;
	assign take = start & ~busy;

	// valid bits are control state and reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op;
			a_s1  <= reg_value;
			m_s1  <= operand;
			st_s1 <= status_in;
		end
	end

	bcdalu_core u_core (
		.op  (op_s1),
		.a   (a_s1),
		.m   (m_s1),
		.st  (st_s1),
		.res (res_comb)
	);

	// result capture
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign done          = valid_s2;
	assign result        = res_s2.result;
	assign status_out    = res_s2.status;
	assign writes_result = res_s2.writes_result;

	// every transfer in yields a done once it has passed stage 1 and stage 2
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##2 done)
		else $error("missing done two cycles after transfer in");

	// no done without a matching earlier transfer in
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 2))
		else $error("done without a matching transfer in");

	// unused op codes produce zero, no write-back, status unchanged
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (op > OP_LOAD)) |-> ##2
			(result == '0 && !writes_result && status_out == $past(status_in, 2)))
		else $error("unused op code altered result or status");

	// the decimal flag is never touched by any operation
	a_dflag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status_out[FLAG_D] == $past(status_in[FLAG_D], 2)))
		else $error("decimal flag changed");

endmodule

@@ hdl/bcdalu_core.sv @@
// combinational datapath: binary/decimal add and subtract, compare, logic, bit test, shifts, inc/dec, load
module bcdalu_core (
	input  bcdalu_pkg::op_code_t op,
	input  bcdalu_pkg::data_t    a,
	input  bcdalu_pkg::data_t    m,
	input  bcdalu_pkg::data_t    st,
	output bcdalu_pkg::alu_res_t res
);
	import bcdalu_pkg::*;

	logic       carry;
	logic       borrow;
	logic       dec_mode;

	// add path
	logic [8:0] add_bin;
	logic       add_v;
	logic [4:0] add_lo;
	logic [5:0] add_lo_adj;
	logic [9:0] add_hi;
	logic [9:0] add_sum;
	logic [9:0] add_sum_adj;

	// subtract path
	logic [8:0] sub_bin;
	logic       sub_v;
	logic [4:0] sub_lo;
	logic [4:0] sub_lo_adj;
	logic [9:0] sub_hi;
	logic [9:0] sub_sum;
	logic [9:0] sub_sum_adj;

	logic [8:0] cmp_diff;
	data_t      r;
	data_t      s;
	logic       wr;

	assign carry    = st[FLAG_C];
	assign borrow   = ~st[FLAG_C];
	assign dec_mode = st[FLAG_D];

	// adc
	always_comb begin
		add_bin = {1'b0, a} + {1'b0, m} + {8'd0, carry};
		add_v   = ~(a[7] ^ m[7]) & (a[7] ^ add_bin[7]);
		add_lo  = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, carry};
		add_hi  = {2'b00, a[7:4], 4'h0} + {2'b00, m[7:4], 4'h0};
		if (add_lo > BCD_DIGIT_MAX) begin
			add_lo_adj = {1'b0, add_lo} + BCD_LO_FIX[5:0];
			add_hi     = add_hi + BCD_HI_STEP;
		end else begin
			add_lo_adj = {1'b0, add_lo};
		end
		add_sum = add_hi + {6'd0, add_lo_adj[3:0]};
		if (add_sum > BCD_HI_MAX) begin
			add_sum_adj = add_sum + BCD_HI_FIX;
		end else begin
			add_sum_adj = add_sum;
		end
	end

	// sbc, two's complement with sign in the top bit
	always_comb begin
		sub_bin = {1'b0, a} - {1'b0, m} - {8'd0, borrow};
		sub_v   = (a[7] ^ m[7]) & (a[7] ^ sub_bin[7]);
		sub_lo  = {1'b0, a[3:0]} - {1'b0, m[3:0]} - {4'd0, borrow};
		sub_hi  = {2'b00, a[7:4], 4'h0} - {2'b00, m[7:4], 4'h0};
		if (sub_lo[4]) begin
			sub_lo_adj = sub_lo - BCD_LO_FIX[4:0];
			sub_hi     = sub_hi - BCD_HI_STEP;
		end else begin
			sub_lo_adj = sub_lo;
		end
		sub_sum = sub_hi + {6'd0, sub_lo_adj[3:0]};
		if (sub_sum[9]) begin
			sub_sum_adj = sub_sum - BCD_HI_FIX;
		end else begin
			sub_sum_adj = sub_sum;
		end
	end

	assign cmp_diff = {1'b0, a} - {1'b0, m};

	always_comb begin
		r  = '0;
		s  = st;
		wr = 1'b1;
		case (op)
			OP_ADC: begin
				if (dec_mode) begin
					r = add_sum_adj[7:0];
					s[FLAG_C] = (add_sum_adj > 10'h0FF);
					s[FLAG_N] = add_sum_adj[7];
					s[FLAG_Z] = (add_bin[7:0] == 8'h00);
				end else begin
					r = add_bin[7:0];
					s[FLAG_C] = add_bin[8];
					s[FLAG_N] = add_bin[7];
					s[FLAG_Z] = (add_bin[7:0] == 8'h00);
				end
				s[FLAG_V] = add_v;
			end
			OP_SBC: begin
				r = dec_mode ? sub_sum_adj[7:0] : sub_bin[7:0];
				s[FLAG_N] = r[7];
				s[FLAG_Z] = (sub_bin[7:0] == 8'h00);
				s[FLAG_C] = ~sub_bin[8];
				s[FLAG_V] = sub_v;
			end
			OP_CMP: begin
				r  = cmp_diff[7:0];
				s[FLAG_C] = ~cmp_diff[8];
				wr = 1'b0;
			end
			OP_AND:  r = a & m;
			OP_ORA:  r = a | m;
			OP_EOR:  r = a ^ m;
			OP_BIT: begin
				r  = a & m;
				s[FLAG_V] = m[6];
				wr = 1'b0;
			end
			OP_ASL: begin
				r = {m[6:0], 1'b0};
				s[FLAG_C] = m[7];
			end
			OP_LSR: begin
				r = {1'b0, m[7:1]};
				s[FLAG_C] = m[0];
			end
			OP_ROL: begin
				r = {m[6:0], carry};
				s[FLAG_C] = m[7];
			end
			OP_ROR: begin
				r = {carry, m[7:1]};
				s[FLAG_C] = m[0];
			end
			OP_INC:  r = m + 8'd1;
			OP_DEC:  r = m - 8'd1;
			OP_LOAD: r = m;
			default: begin
				r  = '0;
				wr = 1'b0;
			end
		endcase

		// common n/z update from the result byte; bit test takes n from the operand
		case (op)
			OP_CMP, OP_AND, OP_ORA, OP_EOR, OP_ASL, OP_LSR, OP_ROL, OP_ROR,
			OP_INC, OP_DEC, OP_LOAD: begin
				s[FLAG_N] = r[7];
				s[FLAG_Z] = (r == 8'h00);
			end
			OP_BIT: begin
				s[FLAG_N] = m[7];
				s[FLAG_Z] = (r == 8'h00);
			end
			default: begin
			end
		endcase
	end

	assign res.result        = r;
	assign res.status        = s;
	assign res.writes_result = wr;

endmodule

@@ sim/tb_bcd_capable_8bit_alu_unit.sv @@
// testbench for the bcd-capable 8-bit alu: directed table, random phases, scoreboard check
module tb_bcd_capable_8bit_alu_unit;

	import bcdalu_pkg::*;

	// op codes the package leaves unassigned
	localparam op_code_t OP_SPARE_LO = 4'd14;
	localparam op_code_t OP_SPARE_HI = 4'd15;

	localparam int RANDOM_PHASES    = 5;
	localparam int OPS_PER_PHASE    = 80;
	localparam int DRAIN_CYCLES     = 8;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int MAX_REPORT_LINES = 100;

	// one row of the directed table
	typedef struct {
		op_code_t code;
		data_t    a;
		data_t    m;
		data_t    st;
		bit       typed;
		alu_res_t want;
	} alu_row_t;

	logic     clk           = 1'b0;
	logic     arst_n        = 1'b0;
	logic     start         = 1'b0;
	logic     busy;
	op_code_t op            = '0;
	data_t    reg_value     = '0;
	data_t    operand       = '0;
	data_t    status_in     = '0;
	logic     done;
	data_t    result;
	data_t    status_out;
	logic     writes_result;

	// typed-in expectation riding along with the operation being offered
	bit       row_typed     = 1'b0;
	alu_res_t row_want      = '0;

	alu_res_t pending_results[$];
	alu_row_t directed_ops[$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;

	bcd_capable_8bit_alu_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (op),
		.reg_value     (reg_value),
		.operand       (operand),
		.status_in     (status_in),
		.done          (done),
		.result        (result),
		.status_out    (status_out),
		.writes_result (writes_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// 6502-style alu with nmos decimal behavior: result byte, new status, write-back flag
	function automatic alu_res_t compute_alu_result(op_code_t code, data_t a, data_t m,
			data_t st_in);
		alu_res_t   res;
		data_t      st;
		data_t      r;
		data_t      binb;
		logic       wr;
		logic       carry;
		logic       nz_from_r;
		logic [8:0] sum9;
		logic [9:0] lo10;
		logic [9:0] hi10;
		logic [9:0] adj;
		int         borrow;
		int         diff;
		int         lo;
		int         hi;
		int         adj_s;
		st        = st_in;
		r         = '0;
		wr        = 1'b1;
		nz_from_r = 1'b1;
		carry     = st_in[FLAG_C];
		case (code)
			OP_ADC: begin
				sum9 = {1'b0, a} + {1'b0, m} + {8'b0, carry};
				if (st_in[FLAG_D]) begin
					// nibble-wise decimal adjust, z still follows the binary sum
					lo10 = {6'b0, a[3:0]} + {6'b0, m[3:0]} + {9'b0, carry};
					hi10 = {2'b0, a[7:4], 4'b0} + {2'b0, m[7:4], 4'b0};
					if (lo10 > 10'h009) begin
						lo10 = lo10 + 10'h006;
						hi10 = hi10 + 10'h010;
					end
					adj = hi10 + {6'b0, lo10[3:0]};
					if (adj > 10'h09F)
						adj = adj + 10'h060;
					r            = adj[7:0];
					st[FLAG_C]   = adj > 10'h0FF;
					st[FLAG_N]   = r[7];
					st[FLAG_Z]   = sum9[7:0] == 8'h00;
					nz_from_r    = 1'b0;
				end else begin
					r          = sum9[7:0];
					st[FLAG_C] = sum9[8];
				end
				st[FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ sum9[7]);
			end
			OP_SBC: begin
				borrow = carry ? 0 : 1;
				diff   = int'(a) - int'(m) - borrow;
				binb   = data_t'(diff);
				if (st_in[FLAG_D]) begin
					lo = int'(a[3:0]) - int'(m[3:0]) - borrow;
					hi = int'(a & 8'hF0) - int'(m & 8'hF0);
					if (lo < 0) begin
						lo = lo - 6;
						hi = hi - 16;
					end
					adj_s = hi + (lo & 15);
					if (adj_s < 0)
						adj_s = adj_s - 96;
					r          = data_t'(adj_s);
					st[FLAG_N] = r[7];
					st[FLAG_Z] = binb == 8'h00;
					nz_from_r  = 1'b0;
				end else begin
					r = binb;
				end
				st[FLAG_C] = diff >= 0;
				st[FLAG_V] = (a[7] ^ m[7]) & (a[7] ^ binb[7]);
			end
			OP_CMP: begin
				r          = a - m;
				st[FLAG_C] = a >= m;
				wr         = 1'b0;
			end
			OP_AND: r = a & m;
			OP_ORA: r = a | m;
			OP_EOR: r = a ^ m;
			OP_BIT: begin
				r          = a & m;
				st[FLAG_Z] = r == 8'h00;
				st[FLAG_V] = m[6];
				st[FLAG_N] = m[7];
				wr         = 1'b0;
				nz_from_r  = 1'b0;
			end
			OP_ASL: begin
				r          = {m[6:0], 1'b0};
				st[FLAG_C] = m[7];
			end
			OP_LSR: begin
				r          = {1'b0, m[7:1]};
				st[FLAG_C] = m[0];
			end
			OP_ROL: begin
				r          = {m[6:0], carry};
				st[FLAG_C] = m[7];
			end
			OP_ROR: begin
				r          = {carry, m[7:1]};
				st[FLAG_C] = m[0];
			end
			OP_INC:  r = m + 8'd1;
			OP_DEC:  r = m - 8'd1;
			OP_LOAD: r = m;
			default: begin
				// spare codes leave the status alone and write nothing
				r         = '0;
				wr        = 1'b0;
				nz_from_r = 1'b0;
			end
		endcase
		if (nz_from_r) begin
			st[FLAG_Z] = r == 8'h00;
			st[FLAG_N] = r[7];
		end
		res.result        = r;
		res.status        = st;
		res.writes_result = wr;
		return res;
	endfunction

	function automatic void add_row(op_code_t code, data_t a, data_t m, data_t st, bit typed,
			data_t r, data_t s, logic w);
		alu_row_t row;
		row.code               = code;
		row.a                  = a;
		row.m                  = m;
		row.st                 = st;
		row.typed              = typed;
		row.want.result        = r;
		row.want.status        = s;
		row.want.writes_result = w;
		directed_ops.push_back(row);
	endfunction

	task automatic report_mismatch(string what, data_t got, data_t want);
		if (mismatch_count < MAX_REPORT_LINES)
			$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// offer one operation at a falling edge, hold it until it transfers in
	task automatic issue_op(op_code_t code, data_t a, data_t m, data_t st, bit typed,
			alu_res_t want, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start     <= 1'b1;
		op        <= code;
		reg_value <= a;
		operand   <= m;
		status_in <= st;
		row_typed <= typed;
		row_want  <= want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	// scoreboard: check the outgoing result first, then log the incoming transfer
	always @(posedge clk) begin
		alu_res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", result, '0);
				end else begin
					want = pending_results.pop_front();
					if (result !== want.result)
						report_mismatch("result", result, want.result);
					if (status_out !== want.status)
						report_mismatch("status_out", status_out, want.status);
					if (writes_result !== want.writes_result)
						report_mismatch("writes_result", data_t'(writes_result),
							data_t'(want.writes_result));
				end
			end
			if (start && !busy) begin
				if (row_typed)
					pending_results.push_back(row_want);
				else
					pending_results.push_back(
						compute_alu_result(op, reg_value, operand, status_in));
			end
		end
	end

	// watchdog on the cycle counter
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int       phase_idle[RANDOM_PHASES];
		op_code_t code;
		data_t    a;
		data_t    m;
		data_t    st;

		// phases: no gaps, heavy sender gaps, light gaps, then again
		phase_idle[0] = 0;
		phase_idle[1] = 70;
		phase_idle[2] = 6;
		phase_idle[3] = 0;
		phase_idle[4] = 70;

		// typed rows are the obvious ones, the rest goes through the predictor
		add_row(OP_ADC,      8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h02, 1'b1);
		add_row(OP_ADC,      8'hFF, 8'hFF, 8'h01, 1'b0, '0, '0, 1'b0);
		add_row(OP_ADC,      8'h7F, 8'h01, 8'h00, 1'b0, '0, '0, 1'b0);
		add_row(OP_ADC,      8'h99, 8'h01, 8'h08, 1'b0, '0, '0, 1'b0);
		add_row(OP_ADC,      8'h58, 8'h46, 8'h09, 1'b0, '0, '0, 1'b0);
		add_row(OP_ADC,      8'hFF, 8'hFF, 8'h09, 1'b0, '0, '0, 1'b0);
		add_row(OP_SBC,      8'h00, 8'h01, 8'h01, 1'b0, '0, '0, 1'b0);
		add_row(OP_SBC,      8'h80, 8'h01, 8'h01, 1'b0, '0, '0, 1'b0);
		add_row(OP_SBC,      8'h00, 8'h01, 8'h09, 1'b0, '0, '0, 1'b0);
		add_row(OP_SBC,      8'hAA, 8'hFF, 8'h08, 1'b0, '0, '0, 1'b0);
		add_row(OP_CMP,      8'h10, 8'h10, 8'h00, 1'b1, 8'h00, 8'h03, 1'b0);
		add_row(OP_CMP,      8'h00, 8'hFF, 8'hFF, 1'b0, '0, '0, 1'b0);
		add_row(OP_AND,      8'hFF, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h80, 1'b1);
		add_row(OP_ORA,      8'h00, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h7F, 1'b1);
		add_row(OP_EOR,      8'hFF, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h02, 1'b1);
		add_row(OP_BIT,      8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'hC2, 1'b0);
		add_row(OP_ASL,      8'hFF, 8'h80, 8'h00, 1'b1, 8'h00, 8'h03, 1'b1);
		add_row(OP_LSR,      8'hFF, 8'h01, 8'h00, 1'b1, 8'h00, 8'h03, 1'b1);
		add_row(OP_ROL,      8'h00, 8'hFF, 8'h01, 1'b0, '0, '0, 1'b0);
		add_row(OP_ROR,      8'h00, 8'h01, 8'h01, 1'b0, '0, '0, 1'b0);
		add_row(OP_INC,      8'h00, 8'hFF, 8'h00, 1'b1, 8'h00, 8'h02, 1'b1);
		add_row(OP_DEC,      8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 8'h80, 1'b1);
		add_row(OP_LOAD,     8'hFF, 8'h00, 8'hFF, 1'b1, 8'h00, 8'h7F, 1'b1);
		add_row(OP_SPARE_LO, 8'hFF, 8'hFF, 8'hA5, 1'b1, 8'h00, 8'hA5, 1'b0);
		add_row(OP_SPARE_HI, 8'h55, 8'hAA, 8'h5A, 1'b1, 8'h00, 8'h5A, 1'b0);

		// reset once, released on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_ops[i])
			issue_op(directed_ops[i].code, directed_ops[i].a, directed_ops[i].m,
				directed_ops[i].st, directed_ops[i].typed, directed_ops[i].want, 0);

		// random part, weighted toward adc/sbc since decimal mode hides most corners
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int n = 0; n < OPS_PER_PHASE; n++) begin
				code = op_code_t'($urandom_range(15));
				a    = data_t'($urandom);
				m    = data_t'($urandom);
				st   = data_t'($urandom);
				if ($urandom_range(99) < 40) begin
					code = $urandom_range(1) ? OP_SBC : OP_ADC;
					// half of these use well-formed bcd digits
					if ($urandom_range(1)) begin
						a = {4'($urandom_range(9)), 4'($urandom_range(9))};
						m = {4'($urandom_range(9)), 4'($urandom_range(9))};
					end
				end
				issue_op(code, a, m, st, 1'b0, '0, phase_idle[ph]);
			end
		end
		start <= 1'b0;

		// wait out the pipeline, then keep watching for stray results
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/bcdalu_pkg.sv
hdl/bcdalu_core.sv
hdl/bcd_capable_8bit_alu_unit.sv
sim/tb_bcd_capable_8bit_alu_unit.sv
